FILE: hw/rtl/adlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package adlm_pkg;

  // Request operation codes
  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Adler-32 modulus, one bit wider than a sum
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam int unsigned SUM_W  = 16;
  localparam int unsigned LINE_W = 16;
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage : adlm_pkg

`default_nettype wire

FILE: hw/rtl/adlm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module adlm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : adlm_ram

`default_nettype wire

FILE: hw/rtl/adler32_line_match_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// in_      | in_valid / in_ready    | operation, data_byte, is_reference
// out_     | out_valid / out_ready  | line_sum, reference_line, line_number,
//          |                        | unmatched, table_full
//
// An append or restart request updates the sums and counters and loads no result.
// Ending a reference line writes the table (unless full) and loads the result register together.
// Ending a checked line walks the reference table through the single RAM read port,
// stopping early when a match is found.
// rst_n (synchronous, active low) empties the table logically (count to 0);
// table contents are never cleared, only entries below the count are read.
// The result sits in an output register; a new request is taken only while
// the engine is idle and that register is empty or being drained.

module adler32_line_match_engine_top #(
  parameter int unsigned REF_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_is_reference,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_line_sum,
  output logic             out_reference_line,
  output logic [15:0]      out_line_number,
  output logic             out_unmatched,
  output logic             out_table_full
);

  import adlm_pkg::*;

  localparam int unsigned AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned CW = $clog2(REF_DEPTH + 1);
  localparam logic [CW-1:0] REF_FULL = CW'(REF_DEPTH);

  state_t state_r, state_nxt;

  // running line sums
  logic [SUM_W-1:0] sum_low_r, sum_high_r;
  logic [16:0]      low_add, high_add;
  logic [SUM_W-1:0] low_nxt, high_nxt;

  // session counters
  logic [CW-1:0]     ref_count_r;
  logic [LINE_W-1:0] ref_lines_r, chk_lines_r;

  // table walk
  logic [CW-1:0]     scan_idx_r;
  logic              cmp_valid_r;
  logic [31:0]       line_sum_r;
  logic [LINE_W-1:0] line_num_r;
  logic [31:0]       rd_data;
  logic              rd_en, scan_hit, scan_end;

  logic        out_valid_r;
  logic        take_in, take_out;
  logic [31:0] cur_sum;
  logic        tbl_full, tbl_we;

  assign take_in  = in_valid && in_ready;
  assign take_out = out_valid_r && out_ready;
  assign cur_sum  = {sum_high_r, sum_low_r};
  assign tbl_full = (ref_count_r == REF_FULL);
  assign tbl_we   = take_in && (in_operation == OP_END) && in_is_reference && !tbl_full;

  // byte fold: two add-and-reduce steps
  always_comb begin
    low_add  = {1'b0, sum_low_r} + {9'd0, in_data_byte};
    low_nxt  = (low_add >= ADLER_MOD) ? SUM_W'(low_add - ADLER_MOD) : low_add[SUM_W-1:0];
    high_add = {1'b0, sum_high_r} + {1'b0, low_nxt};
    high_nxt = (high_add >= ADLER_MOD) ? SUM_W'(high_add - ADLER_MOD) : high_add[SUM_W-1:0];
  end

  assign scan_hit = cmp_valid_r && (rd_data == line_sum_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take_in && (in_operation == OP_END) && !in_is_reference) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    scan_end = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      ST_SCAN: begin
        rd_en    = (scan_idx_r != ref_count_r) && !scan_hit;
        scan_end = scan_hit || ((scan_idx_r == ref_count_r) && !cmp_valid_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  adlm_ram #(
    .WIDTH (32),
    .DEPTH (REF_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ref_count_r[AW-1:0]),
    .wdata (cur_sum),
    .re    (rd_en),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_low_r   <= SUM_W'(1);
      sum_high_r  <= '0;
      ref_count_r <= '0;
      ref_lines_r <= '0;
      chk_lines_r <= '0;
      scan_idx_r  <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (take_out) begin
        out_valid_r <= 1'b0;
      end

      if (take_in) begin
        unique case (in_operation)
          OP_APPEND: begin
            sum_low_r  <= low_nxt;
            sum_high_r <= high_nxt;
          end
          OP_END: begin
            sum_low_r  <= SUM_W'(1);
            sum_high_r <= '0;
            if (in_is_reference) begin
              if (ref_lines_r != LINE_MAX) begin
                ref_lines_r <= ref_lines_r + 1'b1;
              end
              if (!tbl_full) begin
                ref_count_r <= ref_count_r + 1'b1;
              end
              out_valid_r <= 1'b1;
            end else begin
              if (chk_lines_r != LINE_MAX) begin
                chk_lines_r <= chk_lines_r + 1'b1;
              end
              scan_idx_r  <= '0;
              cmp_valid_r <= 1'b0;
            end
          end
          OP_RESTART: begin
            sum_low_r   <= SUM_W'(1);
            sum_high_r  <= '0;
            ref_count_r <= '0;
            ref_lines_r <= '0;
            chk_lines_r <= '0;
          end
          default: begin
            // unused code: no effect
          end
        endcase
      end

      if (state_r == ST_SCAN) begin
        cmp_valid_r <= rd_en;
        if (rd_en) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (scan_end) begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_in && (in_operation == OP_END)) begin
      line_sum_r <= cur_sum;
      line_num_r <= in_is_reference ? ref_lines_r : chk_lines_r;
      if (in_is_reference) begin
        out_line_sum       <= cur_sum;
        out_reference_line <= 1'b1;
        out_line_number    <= ref_lines_r;
        out_unmatched      <= 1'b0;
        out_table_full     <= tbl_full;
      end
    end
    if ((state_r == ST_SCAN) && scan_end) begin
      out_line_sum       <= line_sum_r;
      out_reference_line <= 1'b0;
      out_line_number    <= line_num_r;
      out_unmatched      <= !scan_hit;
      out_table_full     <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule : adler32_line_match_engine_top

`default_nettype wire
